/* hw/rtl/row_selection_bitmap_assert.svh */
// Assertion macros used by the row selection bitmap controller.
`ifndef ROW_SELECTION_BITMAP_ASSERT_SVH
`define ROW_SELECTION_BITMAP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RSB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("row selection bitmap check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RSB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("row selection bitmap check failed");

`endif

/* hw/rtl/rsb_pkg.sv */
// Shared types and constants for the row selection bitmap.
`default_nettype none
package rsb_pkg;

    localparam int MAX_ROWS_DEF = 1024;
    localparam int WORD_BITS    = 32;
    localparam logic [WORD_BITS-1:0] ALL_ONES = 32'hffff_ffff;

    localparam int MODE_W   = 3;
    localparam int ROW_W    = 10;
    localparam int COL_W    = 8;
    localparam int TROWS_W  = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ROWS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODEL_ATTACHED = 2'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLICK      = 3'd0,
        MODE_SHIFT      = 3'd1,
        MODE_CTRL       = 3'd2,
        MODE_INSERT     = 3'd3,
        MODE_DELETE     = 3'd4,
        MODE_INVALIDATE = 3'd5,
        MODE_QUERY      = 3'd6
    } mode_t;

    typedef struct packed {
        logic load_item;
        logic plan;
        logic sweep_read;
        logic publish;
    } rsb_cmd_t;

    typedef struct packed {
        logic need_sweep;
        logic last_read;
    } rsb_status_t;

endpackage
`default_nettype wire

/* hw/rtl/rsb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* hw/rtl/rsb_ctrl.sv */
// Controller state machine: item sequencing, word sweep and result handoff.
`default_nettype none
`include "row_selection_bitmap_assert.svh"
module rsb_ctrl
    import rsb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    input  wire rsb_status_t status,
    output rsb_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_SWEEP,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    // Decode commands from the current state
    always_comb
    begin
        cmd.load_item  = (state_reg == ST_IDLE) && in_valid;
        cmd.plan       = (state_reg == ST_PLAN);
        cmd.sweep_read = (state_reg == ST_SWEEP);
        cmd.publish    = (state_reg == ST_RESULT) && (!out_valid_reg || !out_stall);
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // Advance state and hold the output beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_PLAN;
                    end
                end
                ST_PLAN:
                begin
                    state_reg <= status.need_sweep ? ST_SWEEP : ST_RESULT;
                end
                ST_SWEEP:
                begin
                    if (status.last_read)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_RESULT;
                end
                ST_RESULT:
                begin
                    if (cmd.publish)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `RSB_ASSERT_NEXT(a_accept_plans, in_valid && !in_stall, state_reg == ST_PLAN)
    `RSB_ASSERT_NEXT(a_last_drains, cmd.sweep_read && status.last_read, state_reg == ST_DRAIN)
    `RSB_ASSERT_NEXT(a_publish_shows, cmd.publish, out_valid_reg && state_reg == ST_IDLE)

endmodule
`default_nettype wire

/* hw/rtl/rsb_datapath.sv */
// Datapath: configuration, row state, word store and per-word update logic.
`default_nettype none
module rsb_datapath
    import rsb_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rsb_cmd_t              cmd,
    output rsb_status_t                status,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [MODE_W-1:0]     mode,
    input  wire logic [ROW_W-1:0]      row,
    input  wire logic [COL_W-1:0]      column,
    output logic                       bitmap_changed,
    output logic                       cursor_moved,
    output logic [ROW_W-1:0]           cursor_row_now,
    output logic [COL_W-1:0]           cursor_column_now,
    output logic                       row_is_selected,
    output logic                       refused
);

    localparam int NWORDS = MAX_ROWS / WORD_BITS;
    localparam int WIW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int LW     = $clog2(MAX_ROWS + 1);
    localparam int CW     = (LW > TROWS_W) ? LW : TROWS_W;
    localparam int XW     = (WIW > 5) ? WIW : 5;

    typedef enum logic [2:0] {
        OP_KEEP,
        OP_CLICK,
        OP_CTRL,
        OP_SET,
        OP_CLR,
        OP_INS,
        OP_DEL
    } sweep_op_t;

    typedef logic [WIW-1:0] wmap_t [32];

    function automatic wmap_t make_wmap();
        wmap_t t;
        for (int i = 0; i < 32; i++)
        begin
            t[i] = WIW'(i % NWORDS);
        end
        return t;
    endfunction

    localparam wmap_t WORD_MAP = make_wmap();

    // Configuration and row state
    logic [TROWS_W-1:0] table_rows_reg;
    logic               attached_reg;
    logic               map_valid_reg;
    logic [LW-1:0]      live_rows_reg;
    logic [ROW_W-1:0]   cursor_row_reg;
    logic [COL_W-1:0]   cursor_col_reg;
    logic [ROW_W-1:0]   anchor_row_reg;

    // Latched item
    logic [MODE_W-1:0]  mode_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;

    // Sweep parameters and result
    sweep_op_t          op_reg;
    logic               old_zero_reg;
    logic               del_dir_reg;
    logic [WIW-1:0]     tidx_reg;
    logic [4:0]         k_reg;
    logic [ROW_W-1:0]   lo_reg;
    logic [ROW_W-1:0]   hi_reg;
    logic               capture_reg;
    logic               refused_reg;
    logic               sel_base_reg;
    logic               cur_chg_reg;
    logic               chg_reg;
    logic               carry_reg;
    logic               answer_reg;
    logic [WIW-1:0]     rd_cnt_reg;
    logic               stage_v_reg;
    logic [WIW-1:0]     stage_idx_reg;

    // Plan results
    sweep_op_t          p_op;
    logic               p_need_sweep;
    logic               p_refused;
    logic               p_sel_base;
    logic               p_capture;
    logic               p_cur_upd;
    logic               p_anchor_upd;
    logic               p_valid_next;
    logic [LW-1:0]      p_live_next;
    logic [ROW_W-1:0]   p_lo;
    logic [ROW_W-1:0]   p_hi;
    logic [LW-1:0]      sat_rows;
    logic [LW-1:0]      eff_live;
    logic               row_ok;
    logic               shrink;
    logic               grow;

    // Word store
    logic [WIW-1:0]       raddr;
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] old_word;
    logic [WORD_BITS-1:0] new_word;
    logic [WORD_BITS-1:0] bit_k;
    logic [WORD_BITS-1:0] keep_hi;
    logic [WORD_BITS-1:0] range_m;
    logic [4:0]           rs;
    logic [4:0]           re;
    logic [XW-1:0]        sidx_x;
    logic [XW-1:0]        lw_x;
    logic [XW-1:0]        hw_x;

    // Saturate the table size and pick the live row count in force
    assign sat_rows = (CW'(table_rows_reg) > CW'(MAX_ROWS)) ? LW'(MAX_ROWS)
                                                            : LW'(table_rows_reg);
    assign eff_live = map_valid_reg ? live_rows_reg : sat_rows;
    assign row_ok   = CW'(row_reg) < CW'(eff_live);

    // Decide direction of a shift click
    always_comb
    begin
        shrink = ((anchor_row_reg < row_reg) && (row_reg <= cursor_row_reg)) ||
                 ((anchor_row_reg >= row_reg) && (row_reg >= cursor_row_reg));
        grow   = ((anchor_row_reg <= cursor_row_reg) && (cursor_row_reg <= row_reg)) ||
                 ((anchor_row_reg > cursor_row_reg) && (cursor_row_reg >= row_reg));
    end

    // Plan the item from the latched fields and the row state
    always_comb
    begin
        p_op         = OP_KEEP;
        p_need_sweep = 1'b0;
        p_refused    = 1'b0;
        p_sel_base   = 1'b0;
        p_capture    = 1'b0;
        p_cur_upd    = 1'b0;
        p_anchor_upd = 1'b0;
        p_valid_next = map_valid_reg;
        p_live_next  = live_rows_reg;
        p_lo         = (cursor_row_reg < row_reg) ? cursor_row_reg : row_reg;
        p_hi         = (cursor_row_reg > row_reg) ? cursor_row_reg : row_reg;
        if (CW'(p_hi) >= CW'(eff_live))
        begin
            p_hi = ROW_W'(eff_live - LW'(1));
        end
        case (mode_reg)
            MODE_CLICK, MODE_SHIFT, MODE_CTRL:
            begin
                if (!attached_reg)
                begin
                    p_refused = 1'b1;
                end
                else
                begin
                    p_need_sweep = 1'b1;
                    p_valid_next = 1'b1;
                    p_live_next  = eff_live;
                    if (!row_ok)
                    begin
                        p_refused = 1'b1;
                    end
                    else if (mode_reg == MODE_SHIFT)
                    begin
                        if (!shrink && !grow)
                        begin
                            p_refused = 1'b1;
                        end
                        else
                        begin
                            p_op       = shrink ? OP_CLR : OP_SET;
                            p_sel_base = 1'b1;
                        end
                    end
                    else if (mode_reg == MODE_CTRL)
                    begin
                        p_op         = OP_CTRL;
                        p_sel_base   = 1'b1;
                        p_anchor_upd = 1'b1;
                    end
                    else
                    begin
                        p_op         = OP_CLICK;
                        p_anchor_upd = 1'b1;
                    end
                    p_cur_upd = !p_refused &&
                                ((cursor_row_reg != row_reg) || (cursor_col_reg != col_reg));
                end
            end
            MODE_INSERT:
            begin
                if (!map_valid_reg || (CW'(row_reg) > CW'(live_rows_reg)) ||
                    (CW'(live_rows_reg) >= CW'(MAX_ROWS)))
                begin
                    p_refused = 1'b1;
                end
                else
                begin
                    p_op         = OP_INS;
                    p_need_sweep = 1'b1;
                    p_live_next  = live_rows_reg + LW'(1);
                end
            end
            MODE_DELETE:
            begin
                if (!map_valid_reg || (CW'(row_reg) >= CW'(live_rows_reg)))
                begin
                    p_refused = 1'b1;
                end
                else
                begin
                    p_op         = OP_DEL;
                    p_need_sweep = 1'b1;
                    p_live_next  = live_rows_reg - LW'(1);
                end
            end
            MODE_INVALIDATE:
            begin
                p_valid_next = 1'b0;
                p_live_next  = '0;
                p_sel_base   = 1'b1;
            end
            MODE_QUERY:
            begin
                if (map_valid_reg && row_ok)
                begin
                    p_need_sweep = 1'b1;
                    p_capture    = 1'b1;
                end
            end
            default:
            begin
                p_refused = 1'b1;
            end
        endcase
    end

    assign status.need_sweep = p_need_sweep;
    assign status.last_read  = (rd_cnt_reg == WIW'(NWORDS - 1));

    // Walk the words upward, or downward for a delete
    assign raddr = del_dir_reg ? (WIW'(NWORDS - 1) - rd_cnt_reg) : rd_cnt_reg;

    rsb_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NWORDS)
    ) u_words (
        .clk   (clk),
        .we    (stage_v_reg),
        .waddr (stage_idx_reg),
        .wdata (new_word),
        .raddr (raddr),
        .rdata (rd_data)
    );

    // Compute the new value of the word in the write stage
    always_comb
    begin
        old_word = old_zero_reg ? '0 : rd_data;
        bit_k    = {1'b1, {(WORD_BITS-1){1'b0}}} >> k_reg;
        keep_hi  = ~(ALL_ONES >> k_reg);
        sidx_x   = XW'(stage_idx_reg);
        lw_x     = XW'(lo_reg[ROW_W-1:5]);
        hw_x     = XW'(hi_reg[ROW_W-1:5]);
        rs       = (sidx_x == lw_x) ? lo_reg[4:0] : 5'd0;
        re       = (sidx_x == hw_x) ? hi_reg[4:0] : 5'd31;
        range_m  = ((sidx_x < lw_x) || (sidx_x > hw_x)) ? '0 :
                   ((ALL_ONES >> rs) & (ALL_ONES << (5'd31 - re)));
        case (op_reg)
            OP_KEEP:
            begin
                new_word = old_word;
            end
            OP_CLICK:
            begin
                new_word = (stage_idx_reg == tidx_reg) ? bit_k : '0;
            end
            OP_CTRL:
            begin
                new_word = (stage_idx_reg == tidx_reg) ? (old_word ^ bit_k) : old_word;
            end
            OP_SET:
            begin
                new_word = old_word | range_m;
            end
            OP_CLR:
            begin
                new_word = old_word & ~range_m;
            end
            OP_INS:
            begin
                if (stage_idx_reg < tidx_reg)
                begin
                    new_word = old_word;
                end
                else if (stage_idx_reg == tidx_reg)
                begin
                    new_word = (old_word & keep_hi) | ((old_word & (ALL_ONES >> k_reg)) >> 1);
                end
                else
                begin
                    new_word = (old_word >> 1) | {carry_reg, {(WORD_BITS-1){1'b0}}};
                end
            end
            OP_DEL:
            begin
                if (stage_idx_reg < tidx_reg)
                begin
                    new_word = old_word;
                end
                else if (stage_idx_reg == tidx_reg)
                begin
                    new_word = (old_word & keep_hi) |
                               ((old_word & ((ALL_ONES >> k_reg) >> 1)) << 1) |
                               WORD_BITS'(carry_reg);
                end
                else
                begin
                    new_word = (old_word << 1) | WORD_BITS'(carry_reg);
                end
            end
            default:
            begin
                new_word = old_word;
            end
        endcase
    end

    // Hold configuration, row state and sweep control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_rows_reg <= '0;
            attached_reg   <= 1'b0;
            map_valid_reg  <= 1'b0;
            live_rows_reg  <= '0;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            anchor_row_reg <= '0;
            stage_v_reg    <= 1'b0;
            rd_cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_TABLE_ROWS:
                    begin
                        table_rows_reg <= cfg_data[TROWS_W-1:0];
                    end
                    CFG_MODEL_ATTACHED:
                    begin
                        attached_reg <= cfg_data[0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.plan)
            begin
                map_valid_reg <= p_valid_next;
                live_rows_reg <= p_live_next;
                rd_cnt_reg    <= '0;
                if (p_cur_upd)
                begin
                    cursor_row_reg <= row_reg;
                    cursor_col_reg <= col_reg;
                end
                if (p_anchor_upd)
                begin
                    anchor_row_reg <= row_reg;
                end
            end
            else if (cmd.sweep_read)
            begin
                rd_cnt_reg <= rd_cnt_reg + WIW'(1);
            end
            stage_v_reg <= cmd.sweep_read;
        end
    end

    // Latch the item, the plan and the running sweep results
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg <= mode;
            row_reg  <= row;
            col_reg  <= column;
        end
        if (cmd.plan)
        begin
            op_reg       <= p_op;
            old_zero_reg <= !map_valid_reg;
            del_dir_reg  <= (p_op == OP_DEL);
            tidx_reg     <= WORD_MAP[row_reg[ROW_W-1:5]];
            k_reg        <= row_reg[4:0];
            lo_reg       <= p_lo;
            hi_reg       <= p_hi;
            capture_reg  <= p_capture;
            refused_reg  <= p_refused;
            sel_base_reg <= p_sel_base;
            cur_chg_reg  <= p_cur_upd;
            chg_reg      <= 1'b0;
            carry_reg    <= 1'b0;
            answer_reg   <= 1'b0;
        end
        else if (stage_v_reg)
        begin
            chg_reg   <= chg_reg | (new_word != old_word);
            carry_reg <= del_dir_reg ? old_word[WORD_BITS-1] : old_word[0];
            if (capture_reg && (stage_idx_reg == tidx_reg))
            begin
                answer_reg <= |(old_word & bit_k);
            end
        end
        stage_idx_reg <= raddr;
        if (cmd.publish)
        begin
            bitmap_changed    <= sel_base_reg | chg_reg;
            cursor_moved      <= cur_chg_reg;
            cursor_row_now    <= cursor_row_reg;
            cursor_column_now <= cursor_col_reg;
            row_is_selected   <= answer_reg;
            refused           <= refused_reg;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/row_selection_bitmap.sv */
// Top level of the row selection bitmap: controller, datapath and config port.
`default_nettype none
// Row selection bitmap: one selection bit per table row, kept in a word store
// of MAX_ROWS/32 words, with a live row count, cursor and anchor. Clicks (when
// a table is attached), an accepted insert or delete and an in-range query on
// a valid map sweep the whole store one word a cycle through a single-write,
// single-read RAM; every other item is done without a sweep. One item is
// worked at a time; the result register lets the next item be accepted while
// a result waits. The store needs no clearing after reset: its content counts
// only after the first click, whose sweep rewrites every word. Configuration
// writes are always taken, as cfg_ready is tied high.
module row_selection_bitmap
    import rsb_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [MODE_W-1:0]     mode,
    input  wire logic [ROW_W-1:0]      row,
    input  wire logic [COL_W-1:0]      column,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       bitmap_changed,
    output logic                       cursor_moved,
    output logic [ROW_W-1:0]           cursor_row_now,
    output logic [COL_W-1:0]           cursor_column_now,
    output logic                       row_is_selected,
    output logic                       refused,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    rsb_cmd_t    cmd;
    rsb_status_t status;

    // Take every configuration beat at once
    assign cfg_ready = 1'b1;

    rsb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    rsb_datapath #(
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_write         (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mode              (mode),
        .row               (row),
        .column            (column),
        .bitmap_changed    (bitmap_changed),
        .cursor_moved      (cursor_moved),
        .cursor_row_now    (cursor_row_now),
        .cursor_column_now (cursor_column_now),
        .row_is_selected   (row_is_selected),
        .refused           (refused)
    );

endmodule
`default_nettype wire
